// ----- rtl/core/rmf_pkg.sv -----
// Shared types, constants and the CRC byte update for the Modbus RTU request framer.
package rmf_pkg;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam int          FRAME_BYTES = 8;
   localparam int          HEAD_BYTES = 6;
   localparam int          POS_W = $clog2(FRAME_BYTES);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

   // Frame head (address, function, register address, value) and running CRC.
   typedef struct packed {
      logic [8*HEAD_BYTES-1:0] frame;
      logic [15:0]             crc;
   } work_type;

   // One byte of the reflected Modbus CRC-16, a bit per step.
   function automatic logic [15:0] crc_add_byte(input logic [15:0] crc_i,
                                                input logic [7:0] data_i);
      logic [15:0] c;
      c = crc_i ^ {8'h00, data_i};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ----- rtl/core/modbus_rtu_request_framer.sv -----
// Top level of the Modbus RTU request framer: CRC pipeline and byte serializer.
//
//   Channel  Direction  Ports                    Contents
//   req      in         req_tvalid/tready/tdata  one request transaction
//   rsp      out        rsp_tvalid/tready/tdata  one frame byte per transaction, tlast on last
//   csr      in         csr_valid/ready/data     device address register write
//
// A request enters a six-stage pipeline; each stage folds one head byte into the
// CRC, and the last stage hands the finished frame to the serializer's register.
// The serializer sends one byte per cycle while rsp is ready, and takes the next
// frame as the current frame's last byte is taken; that register sets the request rate.
// Reset is synchronous and empties every stage and the serializer.
// A stall on rsp holds the current byte and backs up the pipeline stage by stage;
// nothing is dropped or sent twice. The pipeline keeps accepting until it is full.
// The device address is sampled when the request transaction happens.
module modbus_rtu_request_framer
   import rmf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] function_code, [23:8] register_address, [39:24] register_value
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] frame_byte
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   localparam int STAGES = HEAD_BYTES;

   logic [7:0] device_address_ff;

   // Index 0 is the request port; index k is the output of CRC stage k-1.
   logic     stage_valid [0:STAGES];
   logic     stage_ready [0:STAGES];
   work_type stage_data  [0:STAGES];

   // The register write is always taken in the cycle it is offered.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= 8'h00;
      end else if (csr_valid) begin
         device_address_ff <= csr_data;
      end
   end

   // The frame head is byte 0 in the top bits, as it goes on the wire.
   assign stage_valid[0]      = req_tvalid;
   assign req_tready          = stage_ready[0];
   assign stage_data[0].frame = {device_address_ff, req_tdata[7:0],
                                 req_tdata[23:8], req_tdata[39:24]};
   assign stage_data[0].crc   = CRC_INIT;

   for (genvar k = 0; k < STAGES; k++) begin : g_crc
      rmf_crc_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[k]),
         .in_ready  (stage_ready[k]),
         .in_data   (stage_data[k]),
         .in_byte   (stage_data[k].frame[8*HEAD_BYTES-1-8*k -: 8]),
         .out_valid (stage_valid[k+1]),
         .out_ready (stage_ready[k+1]),
         .out_data  (stage_data[k+1])
      );
   end

   rmf_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[STAGES]),
      .in_ready  (stage_ready[STAGES]),
      .in_data   (stage_data[STAGES]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule

// ----- rtl/core/rmf_crc_stage.sv -----
// One pipeline stage that folds one frame byte into the running CRC.
module rmf_crc_stage
   import rmf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  work_type in_data,
   input  logic [7:0] in_byte,
   output logic     out_valid,
   input  logic     out_ready,
   output work_type out_data
);

   logic     valid_ff;
   logic     valid_in;
   work_type data_ff;
   work_type data_in;

   // The stage moves whenever it is empty or its content is leaving.
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (in_ready) begin
         valid_in = in_valid;
         if (in_valid) begin
            data_in.frame = in_data.frame;
            data_in.crc   = crc_add_byte(in_data.crc, in_byte);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- rtl/core/rmf_serializer.sv -----
// Output register that sends a finished frame one byte per transaction.
module rmf_serializer
   import rmf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  work_type   in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [7:0] out_byte,
   output logic       out_last
);

   logic                     valid_ff;
   logic                     valid_in;
   logic [POS_W-1:0]         pos_ff;
   logic [POS_W-1:0]         pos_in;
   logic [8*FRAME_BYTES-1:0] shift_ff;
   logic [8*FRAME_BYTES-1:0] shift_in;
   logic                     is_last;
   logic                     load;

   assign is_last  = (pos_ff == LAST_POS);
   assign in_ready = !valid_ff || (out_ready && is_last);
   assign load     = in_ready && in_valid;

   always_comb begin
      valid_in = valid_ff;
      pos_in   = pos_ff;
      shift_in = shift_ff;
      if (load) begin
         // CRC travels low byte first.
         valid_in = 1'b1;
         pos_in   = '0;
         shift_in = {in_data.frame, in_data.crc[7:0], in_data.crc[15:8]};
      end else if (in_ready) begin
         valid_in = 1'b0;
      end else if (out_ready) begin
         pos_in   = pos_ff + 1'b1;
         shift_in = {shift_ff[8*FRAME_BYTES-9:0], 8'h00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
      shift_ff <= shift_in;
   end

   assign out_valid = valid_ff;
   assign out_byte  = shift_ff[8*FRAME_BYTES-1 -: 8];
   assign out_last  = is_last;

endmodule

// ----- rtl/core/rmf_checker.sv -----
// Port-level checker for the Modbus RTU request framer, bound to the top level.
module rmf_checker
   import rmf_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast
);

   logic [POS_W-1:0] beat_ff;
   logic [3:0]       open_ff;
   logic             req_take;
   logic             rsp_take;
   logic             frame_done;

   assign req_take   = req_tvalid && req_tready;
   assign rsp_take   = rsp_tvalid && rsp_tready;
   assign frame_done = rsp_take && rsp_tlast;

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= '0;
         open_ff <= '0;
      end else begin
         if (rsp_take) begin
            beat_ff <= beat_ff + 1'b1;
         end
         open_ff <= open_ff + {3'b000, req_take} - {3'b000, frame_done};
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp transaction changed while stalled");

   a_last_eighth: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (beat_ff == LAST_POS)))
      else $error("tlast not on the eighth byte of a frame");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (open_ff != 4'd0))
      else $error("frame byte without an open request");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      open_ff <= 4'd7)
      else $error("more requests in flight than the pipeline holds");

   // Checked on the first edge after reset is released.
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("output valid right after reset");

endmodule

bind modbus_rtu_request_framer rmf_checker u_checker (.*);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the Modbus RTU request framer: stream driver, monitor, predictor.
//
// Requests are placed in a queue by the stimulus thread. A clocked driver offers them on the
// req stream. When a request transaction completes, the driver predicts the eight frame bytes
// that must follow and appends them to the queue of due bytes. A clocked monitor pops the
// oldest due byte for every rsp transaction and compares the byte and tlast. The device
// address register is written only while the framer is empty, so the predictor can simply
// use a local copy of it at the moment of each request transaction.
module tb_top
   import rmf_pkg::*;
();

   // Request layout on req_tdata, lowest bits first: function code, address, value.
   typedef struct packed {
      logic [15:0] value;
      logic [15:0] address;
      logic [7:0]  fcode;
   } modbus_request_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } frame_byte_type;

   localparam int HOLD_CYCLES   = 300;   // long receiver hold-off that backs up the framer
   localparam int SETTLE_CYCLES = 20;    // settle time before a register write, so it lands on an empty framer

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data   = '0;

   modbus_request_type pending_requests[$];
   frame_byte_type     frame_bytes_due[$];
   logic [7:0]         device_address_copy = 8'h00;
   int                 requests_queued     = 0;
   int                 requests_accepted   = 0;
   int                 sender_idle_pct     = 0;
   int                 receiver_idle_pct   = 0;
   int                 mismatches          = 0;
   logic               hold_go             = 1'b0;
   logic               hold_go_q           = 1'b0;
   int                 hold_left           = 0;

   modbus_rtu_request_framer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Modbus CRC-16 over the six head bytes, most significant byte of the head first.
   // Each data bit is shifted in LSB first and the reflected polynomial is applied on carry.
   function automatic logic [15:0] modbus_crc16(input logic [47:0] head);
      logic [15:0] crc;
      logic        carry;
      crc = CRC_INIT;
      for (int i = 5; i >= 0; i--) begin
         for (int j = 0; j < 8; j++) begin
            carry = crc[0] ^ head[8*i + j];
            crc   = crc >> 1;
            if (carry) begin
               crc = crc ^ CRC_POLY;
            end
         end
      end
      return crc;
   endfunction

   // Appends the eight bytes that one request must produce: the head in order, then the
   // CRC low byte and the CRC high byte, which is the only one marked as last.
   function automatic void frame_modbus_request(input modbus_request_type rq);
      logic [47:0] head;
      logic [15:0] crc;
      head = {device_address_copy, rq.fcode, rq.address, rq.value};
      crc  = modbus_crc16(head);
      for (int i = 5; i >= 0; i--) begin
         frame_bytes_due.push_back('{data: head[8*i +: 8], last: 1'b0});
      end
      frame_bytes_due.push_back('{data: crc[7:0], last: 1'b0});
      frame_bytes_due.push_back('{data: crc[15:8], last: 1'b1});
      requests_accepted++;
   endfunction

   // Request driver. A new request may be placed on the bus whenever the current one has
   // been taken (or nothing is offered). The prediction and the accepted count are updated
   // together so the stimulus thread never sees one without the other.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            frame_modbus_request(modbus_request_type'(req_tdata));
         end
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_tdata  <= pending_requests.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Frame byte monitor. Every rsp transaction is matched against the oldest due byte.
   always @(posedge clock) begin
      frame_byte_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (frame_bytes_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("tb_top: unexpected frame byte %02h last %b", rsp_tdata, rsp_tlast);
               end
            end else begin
               want = frame_bytes_due.pop_front();
               if (rsp_tdata !== want.data || rsp_tlast !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display({"tb_top: frame byte mismatch, ",
                               "expected %02h last %b, got %02h last %b"},
                              want.data, want.last, rsp_tdata, rsp_tlast);
                  end
               end
            end
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // Long receiver hold-off, started by a rising hold_go and counted down here.
   always @(posedge clock) begin
      hold_go_q <= hold_go;
      if (reset) begin
         hold_left <= 0;
      end else if (hold_go && !hold_go_q) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   task automatic queue_request(input logic [7:0] fcode, input logic [15:0] address,
                                input logic [15:0] value);
      pending_requests.push_back('{value: value, address: address, fcode: fcode});
      requests_queued++;
   endtask

   // Mostly common function codes with random fields, the rest fully random bytes.
   task automatic queue_random_requests(input int count);
      logic [7:0] fcode;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(9))
            0, 1, 2: fcode = 8'h06;
            3, 4:    fcode = 8'h03;
            5:       fcode = 8'h10;
            6:       fcode = 8'h04;
            default: fcode = 8'($urandom);
         endcase
         queue_request(fcode, 16'($urandom), 16'($urandom));
      end
   endtask

   // Waits until every queued request has been taken and all its bytes have arrived, then
   // lets the pipeline settle so a register write lands on an empty framer.
   task automatic wait_until_idle();
      while (requests_accepted != requests_queued || frame_bytes_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_device_address(input logic [7:0] value);
      @(posedge clock);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      device_address_copy = value;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed requests with a zero device address: field extremes, alternating bit
      // patterns and a spread of function codes, valid or not.
      sender_idle_pct   = 33;
      receiver_idle_pct = 84;
      write_device_address(8'h00);
      queue_request(8'h00, 16'h0000, 16'h0000);
      queue_request(8'hFF, 16'hFFFF, 16'hFFFF);
      queue_request(8'h06, 16'h0001, 16'h00FA);
      queue_request(8'h03, 16'h0000, 16'h000A);
      queue_request(8'h10, 16'h8000, 16'h7FFF);
      queue_request(8'h06, 16'hAAAA, 16'h5555);
      queue_request(8'h05, 16'h5555, 16'hAAAA);
      queue_request(8'h01, 16'hFF00, 16'h00FF);
      queue_request(8'h80, 16'h00FF, 16'hFF00);
      queue_request(8'h04, 16'h1234, 16'hABCD);
      queue_request(8'h7F, 16'h0102, 16'h0304);
      queue_request(8'h06, 16'hFFFF, 16'h0000);
      queue_request(8'h06, 16'h0000, 16'hFFFF);
      queue_request(8'hAA, 16'h7FFF, 16'h8000);
      queue_request(8'h55, 16'h0001, 16'h0001);
      wait_until_idle();

      // All-ones device address, same idling mix.
      write_device_address(8'hFF);
      queue_random_requests(85);
      wait_until_idle();

      // Random device address with the idling roles swapped.
      sender_idle_pct   = 84;
      receiver_idle_pct = 33;
      write_device_address(8'($urandom_range(254, 1)));
      queue_random_requests(85);
      wait_until_idle();

      // No idling at all. The receiver first holds off for a long stretch while the driver
      // keeps offering, so the pipeline fills and req_tready must drop.
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      write_device_address(8'h01);
      @(posedge clock);
      hold_go <= 1'b1;
      queue_random_requests(75);
      wait_until_idle();

      if (mismatches == 0 && frame_bytes_due.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb_top: done, errors");
      $finish;
   end

endmodule
